[rtl/universal_machine_execute_unit_macros.svh]
// Assertion macros for the universal machine execute unit
`ifndef UNIVERSAL_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define UNIVERSAL_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define UMEU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define UMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/umeu_pkg.sv]
// Shared types and constants for the universal machine execute unit
package umeu_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegW = 3;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned ActW = 4;
  localparam int unsigned CntW = 6;

  localparam logic [3:0] OP_CMOV = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_STORE = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_NAND = 4'd6;
  localparam logic [3:0] OP_MAP = 4'd8;
  localparam logic [3:0] OP_UNMAP = 4'd9;
  localparam logic [3:0] OP_OUT = 4'd10;
  localparam logic [3:0] OP_LOADPROG = 4'd12;
  localparam logic [3:0] OP_LOADIMM = 4'd13;

  localparam logic [ActW-1:0] ACT_DONE = 4'd0;
  localparam logic [ActW-1:0] ACT_LOAD = 4'd1;
  localparam logic [ActW-1:0] ACT_STORE = 4'd2;
  localparam logic [ActW-1:0] ACT_MAP = 4'd3;
  localparam logic [ActW-1:0] ACT_UNMAP = 4'd4;
  localparam logic [ActW-1:0] ACT_OUTPUT = 4'd5;
  localparam logic [ActW-1:0] ACT_LOADPROG = 4'd6;
  localparam logic [ActW-1:0] ACT_HALT = 4'd7;
  localparam logic [ActW-1:0] ACT_DIVFAULT = 4'd8;

  typedef struct packed {
    logic capture;
    logic execute;
    logic div_start;
    logic div_step;
    logic div_finish;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic is_div;
    logic div_zero;
    logic div_last;
  } status_t;
endpackage

[rtl/umeu_datapath.sv]
// Register file, decode, ALU and iterative divider of the execute unit
module umeu_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  umeu_pkg::cmd_t                  cmd,
  output umeu_pkg::status_t               status,
  input  logic                            in_func,
  input  logic [31:0]                     in_instr_word,
  input  logic [umeu_pkg::RegW-1:0]       in_write_reg,
  input  logic [umeu_pkg::DataW-1:0]      in_write_value,
  output logic [umeu_pkg::ActW-1:0]       res_action,
  output logic [umeu_pkg::DataW-1:0]      res_first,
  output logic [umeu_pkg::DataW-1:0]      res_second,
  output logic [umeu_pkg::DataW-1:0]      res_third,
  output logic [umeu_pkg::RegW-1:0]       res_dest
);
  logic [umeu_pkg::DataW-1:0] regs_r [umeu_pkg::NumRegs];
  logic                       halted_r;
  logic                       func_r;
  logic [31:0]                word_r;
  logic [umeu_pkg::RegW-1:0]  wreg_r;
  logic [umeu_pkg::DataW-1:0] wval_r;
  logic [umeu_pkg::DataW-1:0] quo_r;
  logic [umeu_pkg::DataW-1:0] rem_r;
  logic [umeu_pkg::DataW-1:0] dvs_r;
  logic [umeu_pkg::CntW-1:0]  cnt_r;

  logic [3:0]                 op;
  logic [umeu_pkg::RegW-1:0]  ra, rb, rc, rimm;
  logic [umeu_pkg::DataW-1:0] va, vb, vc;
  logic [umeu_pkg::DataW:0]   trial;
  logic [umeu_pkg::DataW-1:0] rem_sh;

  assign op   = word_r[31:28];
  assign ra   = word_r[8:6];
  assign rb   = word_r[5:3];
  assign rc   = word_r[2:0];
  assign rimm = word_r[27:25];
  assign va   = regs_r[ra];
  assign vb   = regs_r[rb];
  assign vc   = regs_r[rc];
  assign rem_sh = {rem_r[umeu_pkg::DataW-2:0], quo_r[umeu_pkg::DataW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  assign status.halted   = halted_r;
  assign status.is_div   = !func_r && (op == umeu_pkg::OP_DIV);
  assign status.div_zero = (vc == '0);
  assign status.div_last = (cnt_r == umeu_pkg::CntW'(umeu_pkg::DataW - 1));

  always_comb begin
    res_action = umeu_pkg::ACT_DONE;
    res_first  = '0;
    res_second = '0;
    res_third  = '0;
    res_dest   = '0;
    if (halted_r) begin
      res_action = umeu_pkg::ACT_HALT;
    end else if (!func_r) begin
      case (op)
        umeu_pkg::OP_CMOV, umeu_pkg::OP_ADD, umeu_pkg::OP_MUL, umeu_pkg::OP_NAND,
        umeu_pkg::OP_LOADIMM: begin
          res_action = umeu_pkg::ACT_DONE;
        end
        umeu_pkg::OP_DIV: begin
          res_action = (vc == '0) ? umeu_pkg::ACT_DIVFAULT : umeu_pkg::ACT_DONE;
        end
        umeu_pkg::OP_LOAD: begin
          res_action = umeu_pkg::ACT_LOAD;
          res_first  = vb;
          res_second = vc;
          res_dest   = ra;
        end
        umeu_pkg::OP_STORE: begin
          res_action = umeu_pkg::ACT_STORE;
          res_first  = va;
          res_second = vb;
          res_third  = vc;
        end
        umeu_pkg::OP_MAP: begin
          res_action = umeu_pkg::ACT_MAP;
          res_first  = vc;
          res_dest   = rb;
        end
        umeu_pkg::OP_UNMAP: begin
          res_action = umeu_pkg::ACT_UNMAP;
          res_first  = vc;
        end
        umeu_pkg::OP_OUT: begin
          res_action = umeu_pkg::ACT_OUTPUT;
          res_first  = {24'd0, vc[7:0]};
        end
        umeu_pkg::OP_LOADPROG: begin
          res_action = umeu_pkg::ACT_LOADPROG;
          res_first  = vb;
          res_second = vc;
        end
        default: begin
          res_action = umeu_pkg::ACT_HALT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      word_r <= in_instr_word;
      wreg_r <= in_write_reg;
      wval_r <= in_write_value;
    end
    if (cmd.div_start) begin
      quo_r <= vb;
      rem_r <= '0;
      dvs_r <= vc;
    end else if (cmd.div_step) begin
      if (!trial[umeu_pkg::DataW]) begin
        rem_r <= trial[umeu_pkg::DataW-1:0];
        quo_r <= {quo_r[umeu_pkg::DataW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[umeu_pkg::DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      cnt_r    <= '0;
      for (int i = 0; i < umeu_pkg::NumRegs; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.div_finish) begin
        regs_r[ra] <= quo_r;
      end
      if (cmd.execute && !halted_r) begin
        if (func_r) begin
          regs_r[wreg_r] <= wval_r;
        end else begin
          case (op)
            umeu_pkg::OP_LOADIMM: regs_r[rimm] <= {7'd0, word_r[24:0]};
            umeu_pkg::OP_CMOV: begin
              if (vc != '0) begin
                regs_r[ra] <= vb;
              end
            end
            umeu_pkg::OP_ADD:  regs_r[ra] <= vb + vc;
            umeu_pkg::OP_MUL:  regs_r[ra] <= vb * vc;
            umeu_pkg::OP_NAND: regs_r[ra] <= ~(vb & vc);
            umeu_pkg::OP_LOAD, umeu_pkg::OP_STORE, umeu_pkg::OP_DIV, umeu_pkg::OP_MAP,
            umeu_pkg::OP_UNMAP, umeu_pkg::OP_OUT, umeu_pkg::OP_LOADPROG: ;
            default: halted_r <= 1'b1;
          endcase
        end
      end
    end
  end
endmodule

[rtl/umeu_ctrl.sv]
// Sequencing state machine of the execute unit
module umeu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  umeu_pkg::status_t status,
  output umeu_pkg::cmd_t    cmd,
  output logic              load_out
);
  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_DIV, S_DIVWB} state_t;
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    load_out      = 1'b0;
    cmd.capture   = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.halted && status.is_div && !status.div_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (!out_valid_r || !out_stall) begin
          cmd.execute   = 1'b1;
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_DIVWB;
        end
      end
      S_DIVWB: begin
        if (!out_valid_r || !out_stall) begin
          cmd.div_finish = 1'b1;
          load_out       = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

[rtl/universal_machine_execute_unit.sv]
// Top level of the universal machine execute unit
// Usage:
//   Input channel (in_valid/in_stall) carries one request: in_func 0 executes
//   in_instr_word, in_func 1 writes in_write_value into register in_write_reg.
//   Result channel (out_valid/out_stall) returns exactly one result per request:
//   action code, up to three register values and a destination register.
//   A request passes the decode state and then loads the output register, which
//   raises out_valid; a divide with a nonzero divisor also runs the one-bit-per-cycle
//   restoring divider (32 steps) in between. The unit takes no new request until
//   the result of the current one has been loaded.
//   The result sits in an output register; while it waits under out_stall the
//   input is stalled and completion holds until the receiver drops out_stall.
//   Reset (rst_n low, synchronous) clears all eight registers, the halt flag
//   and the valid state. After a halt every request answers action halt.
//   out_stall never drops or alters a pending result.
`include "universal_machine_execute_unit_macros.svh"
module universal_machine_execute_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [31:0]                    in_instr_word,
  input  logic [umeu_pkg::RegW-1:0]      in_write_reg,
  input  logic [umeu_pkg::DataW-1:0]     in_write_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [umeu_pkg::ActW-1:0]      out_action,
  output logic [umeu_pkg::DataW-1:0]     out_first_value,
  output logic [umeu_pkg::DataW-1:0]     out_second_value,
  output logic [umeu_pkg::DataW-1:0]     out_third_value,
  output logic [umeu_pkg::RegW-1:0]      out_dest_reg
);
  umeu_pkg::cmd_t              cmd;
  umeu_pkg::status_t           status;
  logic                        load_out;
  logic [umeu_pkg::ActW-1:0]   res_action;
  logic [umeu_pkg::DataW-1:0]  res_first, res_second, res_third;
  logic [umeu_pkg::RegW-1:0]   res_dest;
  logic [umeu_pkg::ActW-1:0]   action_r;
  logic [umeu_pkg::DataW-1:0]  first_r, second_r, third_r;
  logic [umeu_pkg::RegW-1:0]   dest_r;

  umeu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd, .load_out
  );

  umeu_datapath u_dp (
    .clk, .rst_n, .cmd, .status, .in_func, .in_instr_word, .in_write_reg,
    .in_write_value, .res_action, .res_first, .res_second, .res_third, .res_dest
  );

  always_ff @(posedge clk) begin
    if (load_out) begin
      action_r <= res_action;
      first_r  <= res_first;
      second_r <= res_second;
      third_r  <= res_third;
      dest_r   <= res_dest;
    end
  end

  assign out_action       = action_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_third_value  = third_r;
  assign out_dest_reg     = dest_r;

  `UMEU_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1,
    $onehot0({cmd.execute, cmd.div_start, cmd.div_step, cmd.div_finish}),
    "conflicting datapath commands")
  `UMEU_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid && out_stall,
    !load_out, "pending result overwritten")
  `UMEU_ASSERT_NEXT(a_halt_sticky, clk, rst_n, status.halted,
    status.halted, "halt flag cleared")
endmodule

[tb/sv/umeu_result_checker.sv]
// Checker that predicts and compares universal machine execute unit results
`timescale 1ns / 1ps
module umeu_result_checker
  import umeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_func,
  input  logic [31:0]       in_instr_word,
  input  logic [RegW-1:0]   in_write_reg,
  input  logic [DataW-1:0]  in_write_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ActW-1:0]   out_action,
  input  logic [DataW-1:0]  out_first_value,
  input  logic [DataW-1:0]  out_second_value,
  input  logic [DataW-1:0]  out_third_value,
  input  logic [RegW-1:0]   out_dest_reg,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [DataW-1:0] first;
    logic [DataW-1:0] second;
    logic [DataW-1:0] third;
    logic [RegW-1:0]  dest;
  } um_result_t;

  logic [DataW-1:0] regs [NumRegs];
  logic             halted;
  um_result_t       expected_results [$];

  assign pending = expected_results.size();

  task automatic execute_request(input logic func, input logic [31:0] word,
                                 input logic [RegW-1:0] wreg,
                                 input logic [DataW-1:0] wval,
                                 output um_result_t res);
    logic [3:0]      op;
    logic [RegW-1:0] a, b, c;
    res = '0;
    op = word[31:28];
    a = word[8:6];
    b = word[5:3];
    c = word[2:0];
    if (halted) begin
      res.action = ACT_HALT;
    end else if (func) begin
      regs[wreg] = wval;
      res.action = ACT_DONE;
    end else begin
      res.action = ACT_DONE;
      case (op)
        OP_LOADIMM: regs[word[27:25]] = {7'd0, word[24:0]};
        OP_CMOV: if (regs[c] != 0) regs[a] = regs[b];
        OP_LOAD: begin
          res.action = ACT_LOAD;
          res.first = regs[b];
          res.second = regs[c];
          res.dest = a;
        end
        OP_STORE: begin
          res.action = ACT_STORE;
          res.first = regs[a];
          res.second = regs[b];
          res.third = regs[c];
        end
        OP_ADD: regs[a] = regs[b] + regs[c];
        OP_MUL: regs[a] = regs[b] * regs[c];
        OP_DIV: begin
          if (regs[c] == 0) res.action = ACT_DIVFAULT;
          else regs[a] = regs[b] / regs[c];
        end
        OP_NAND: regs[a] = ~(regs[b] & regs[c]);
        OP_MAP: begin
          res.action = ACT_MAP;
          res.first = regs[c];
          res.dest = b;
        end
        OP_UNMAP: begin
          res.action = ACT_UNMAP;
          res.first = regs[c];
        end
        OP_OUT: begin
          res.action = ACT_OUTPUT;
          res.first = {24'd0, regs[c][7:0]};
        end
        OP_LOADPROG: begin
          res.action = ACT_LOADPROG;
          res.first = regs[b];
          res.second = regs[c];
        end
        default: begin
          halted = 1'b1;
          res.action = ACT_HALT;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    um_result_t res;
    um_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) regs[i] = '0;
      halted = 1'b0;
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_action, out_first_value, out_second_value, out_third_value,
                out_dest_reg};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          mismatches <= mismatches + 1;
        end else begin
          res = expected_results.pop_front();
          if (got !== res) begin
            $display("%0t: mismatch expected act=%0d v1=%h v2=%h v3=%h dst=%0d",
                     $time, res.action, res.first, res.second, res.third, res.dest);
            $display("%0t:            actual act=%0d v1=%h v2=%h v3=%h dst=%0d",
                     $time, got.action, got.first, got.second, got.third, got.dest);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        execute_request(in_func, in_instr_word, in_write_reg, in_write_value, res);
        expected_results.push_back(res);
      end
    end
  end

endmodule

[tb/sv/tb_universal_machine_execute_unit.sv]
// Testbench top for the universal machine execute unit: stimulus and verdict
`timescale 1ns / 1ps
module tb_universal_machine_execute_unit;
  import umeu_pkg::*;

  localparam logic [3:0] OP_HALT_A = 4'd7;
  localparam logic [3:0] OP_HALT_B = 4'd11;
  localparam logic [3:0] OP_HALT_C = 4'd14;
  localparam logic [3:0] OP_HALT_D = 4'd15;
  localparam int NumRandom = 800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [31:0] in_instr_word = '0;
  logic [RegW-1:0] in_write_reg = '0;
  logic [DataW-1:0] in_write_value = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [ActW-1:0] out_action;
  logic [DataW-1:0] out_first_value, out_second_value, out_third_value;
  logic [RegW-1:0] out_dest_reg;
  int mismatches;
  int pending;
  int results_taken = 0;

  always #6 clk = ~clk;

  universal_machine_execute_unit dut (.*);

  umeu_result_checker checker_i (.*);

  function automatic logic [31:0] reg_op(logic [3:0] op, logic [2:0] a, logic [2:0] b,
                                         logic [2:0] c);
    logic [31:0] w;
    w = $urandom;
    return {op, w[27:9], a, b, c};
  endfunction

  function automatic logic [31:0] load_imm(logic [2:0] a, logic [24:0] imm);
    return {OP_LOADIMM, a, imm};
  endfunction

  task automatic send_request(input logic func, input logic [31:0] word,
                              input logic [2:0] wreg, input logic [31:0] wval);
    int gap;
    gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_instr_word <= word;
    in_write_reg <= wreg;
    in_write_value <= wval;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_instr(input logic [31:0] word);
    send_request(1'b0, word, 3'($urandom), $urandom);
  endtask

  task automatic send_write(input logic [2:0] wreg, input logic [31:0] wval);
    send_request(1'b1, $urandom, wreg, wval);
  endtask

  // receiver: random stalls, one long hold-off to back up the input
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (results_taken == 40) hold = 300;
      else hold = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [3:0] ops [12];
    logic [3:0] halts [4];
    int kind;
    logic [31:0] v;
    ops = '{OP_CMOV, OP_LOAD, OP_STORE, OP_ADD, OP_MUL, OP_DIV, OP_NAND,
            OP_MAP, OP_UNMAP, OP_OUT, OP_LOADPROG, OP_DIV};
    halts = '{OP_HALT_A, OP_HALT_B, OP_HALT_C, OP_HALT_D};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_write(3'd0, 32'hFFFF_FFFF);
    send_write(3'd7, 32'h0);
    send_instr(load_imm(3'd6, 25'h1FF_FFFF));
    send_instr(load_imm(3'd5, 25'h0));
    send_write(3'd1, 32'h8000_0001);
    send_instr(reg_op(OP_CMOV, 3'd2, 3'd0, 3'd7));
    send_instr(reg_op(OP_CMOV, 3'd2, 3'd0, 3'd1));
    send_instr(reg_op(OP_ADD, 3'd3, 3'd0, 3'd1));
    send_instr(reg_op(OP_MUL, 3'd4, 3'd0, 3'd1));
    send_instr(reg_op(OP_DIV, 3'd3, 3'd0, 3'd6));
    send_instr(reg_op(OP_DIV, 3'd3, 3'd0, 3'd7));
    send_instr(reg_op(OP_DIV, 3'd3, 3'd0, 3'd0));
    send_instr(reg_op(OP_NAND, 3'd5, 3'd0, 3'd1));
    send_instr(reg_op(OP_LOAD, 3'd7, 3'd0, 3'd1));
    send_instr(reg_op(OP_STORE, 3'd0, 3'd1, 3'd6));
    send_instr(reg_op(OP_MAP, 3'd0, 3'd7, 3'd6));
    send_instr(reg_op(OP_UNMAP, 3'd0, 3'd0, 3'd1));
    send_instr(reg_op(OP_OUT, 3'd0, 3'd0, 3'd0));
    send_instr(reg_op(OP_LOADPROG, 3'd0, 3'd1, 3'd6));

    for (int n = 0; n < NumRandom; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        v = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
        send_write(3'($urandom), v);
      end else if (kind < 4) begin
        send_instr(load_imm(3'($urandom), 25'($urandom)));
      end else begin
        send_instr(reg_op(ops[$urandom_range(0, 11)], 3'($urandom), 3'($urandom),
                          3'($urandom)));
      end
    end

    // halt, then everything answers halt
    send_instr(reg_op(OP_HALT_A, 3'd0, 3'd0, 3'd0));
    for (int n = 0; n < 4; n++) begin
      send_instr(reg_op(halts[n], 3'($urandom), 3'($urandom), 3'($urandom)));
      send_write(3'($urandom), $urandom);
      send_instr(reg_op(OP_ADD, 3'd1, 3'd2, 3'd3));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
